>>> hdl/pd_pkg.sv
// Shared types, character codes and hex digit decode for the percent decoder.
`default_nettype none
package pd_pkg;

    localparam int CFG_W = 11;
    localparam int LEN_W = 10;
    localparam logic [CFG_W-1:0] CAP_RESET = 11'd640;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TOOBIG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        status_t          status;
        logic             done;
        logic             byte_v;
        logic [7:0]       data;
    } res_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> hdl/percent_decoder.sv
// Form-urlencoded percent decoder, one source item per cycle while s_tready is high.
// A result is registered in the result register, or in the skid while m_ stalls.
// Throughput: one item per cycle while the skid is empty; a two-deep output
// (result register plus skid) keeps s_tready high while one result waits.
// Reset (aresetn low, synchronous): escape state, count, drop flag and output
// valids clear; cap_reg returns to 640.
`default_nettype none
module percent_decoder
    import pd_pkg::*;
#(
    parameter int MAX_CAPACITY = 1024
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] in_byte
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [23:0]           m_tdata,   // [7:0] out_byte, [9:8] status, [19:10] length
    output logic                  m_tuser,   // [0] byte_valid
    output logic                  m_tlast,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int CNT_W = (MAX_CAPACITY > 2) ? $clog2(MAX_CAPACITY) : 1;
    localparam int MAXC_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W = ((MAXC_W > CFG_W) ? MAXC_W : CFG_W) + 1;

    logic [CFG_W-1:0] cap_reg;
    phase_t           phase_reg, phase_next;
    logic [3:0]       nib_reg, nib_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             drop_reg, drop_next;

    res_t res_next;
    logic res_valid;
    res_t out_reg, skid_reg;
    logic out_valid_reg, skid_valid_reg;

    logic             accept;
    logic [CMP_W-1:0] cap_eff;
    logic [CMP_W-1:0] count_inc;
    hex_t             hex;
    logic             have_byte, do_fail;
    status_t          fail_st;
    logic [7:0]       dec_byte;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;

    assign cap_eff   = (CMP_W'(cap_reg) > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY)
                                                                : CMP_W'(cap_reg);
    assign count_inc = CMP_W'(count_reg) + CMP_W'(1);
    assign hex       = hex_digit(s_tdata);

    always_comb begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        res_next   = '0;
        res_valid  = 1'b0;
        have_byte  = 1'b0;
        do_fail    = 1'b0;
        fail_st    = ST_INVALID;
        dec_byte   = s_tdata;

        if (drop_reg) begin
            if (s_tlast) begin
                phase_next = PH_IDLE;
                nib_next   = 4'd0;
                count_next = '0;
                drop_next  = 1'b0;
            end
        end else if (cap_reg == '0) begin
            do_fail = 1'b1;
        end else begin
            case (phase_reg)
                PH_HIGH: begin
                    if (!hex.ok || s_tlast) begin
                        do_fail = 1'b1;
                    end else begin
                        nib_next   = hex.val;
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (!hex.ok) begin
                        do_fail = 1'b1;
                    end else begin
                        dec_byte   = {nib_reg, hex.val};
                        have_byte  = 1'b1;
                        phase_next = PH_IDLE;
                        nib_next   = 4'd0;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                    if (s_tdata == CHAR_PCT) begin
                        if (s_tlast) begin
                            do_fail = 1'b1;
                        end else begin
                            phase_next = PH_HIGH;
                        end
                    end else begin
                        dec_byte  = (s_tdata == CHAR_PLUS) ? CHAR_SPACE : s_tdata;
                        have_byte = 1'b1;
                    end
                end
            endcase

            if (have_byte) begin
                if (dec_byte == 8'd0) begin
                    do_fail = 1'b1;
                end else if (count_inc >= cap_eff) begin
                    do_fail = 1'b1;
                    fail_st = ST_TOOBIG;
                end else begin
                    res_valid       = 1'b1;
                    res_next.data   = dec_byte;
                    res_next.byte_v = 1'b1;
                    count_next      = count_inc[CNT_W-1:0];
                    if (s_tlast) begin
                        res_next.done = 1'b1;
                        res_next.len  = count_inc[LEN_W-1:0];
                        phase_next    = PH_IDLE;
                        nib_next      = 4'd0;
                        count_next    = '0;
                    end
                end
            end
        end

        if (do_fail) begin
            phase_next      = PH_IDLE;
            nib_next        = 4'd0;
            count_next      = '0;
            drop_next       = !s_tlast;
            res_valid       = 1'b1;
            res_next        = '0;
            res_next.done   = 1'b1;
            res_next.status = fail_st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg        <= CAP_RESET;
            phase_reg      <= PH_IDLE;
            nib_reg        <= 4'd0;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                nib_reg   <= nib_next;
                count_reg <= count_next;
                drop_reg  <= drop_next;
            end
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_reg        <= skid_reg;
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_reg       <= res_next;
                    out_valid_reg <= accept && res_valid;
                end
            end else if (accept && res_valid) begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.len, out_reg.status, out_reg.data};
    assign m_tuser  = out_reg.byte_v;
    assign m_tlast  = out_reg.done;

endmodule
`default_nettype wire

>>> hdl/pd_checker.sv
// Port-level checks for the percent decoder and their bind to the top level.
`default_nettype none
module pd_checker
    import pd_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_empty_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[9:8] != ST_OK)
        else $error("item without byte is not an error end");

    a_mid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser && m_tdata[9:8] == ST_OK && m_tdata[19:10] == 10'd0)
        else $error("non-final item carries status or length");

    a_no_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[7:0] != 8'd0 && m_tdata[9:8] == ST_OK)
        else $error("decoded byte is zero or byte item has error");

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9:8] != ST_OK |-> m_tdata[19:10] == 10'd0 && m_tdata[7:0] == 8'd0)
        else $error("error item carries length or data");

endmodule

bind percent_decoder pd_checker u_pd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
